FILE: rtl/core/chd_pkg.sv
// ----------------------------------------------------------------------------
// chd_pkg: shared types and constants for the chunked body decoder
// Request and result payloads, status codes, framing characters, hex decode.
// ----------------------------------------------------------------------------
package chd_pkg;

    // default width of the chunk size counter
    localparam int SIZE_BITS_DEFAULT = 32;

    // framing characters
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // result status codes
    localparam logic [1:0] ST_BODY      = 2'd0;
    localparam logic [1:0] ST_COMPLETE  = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    // one input request
    typedef struct packed {
        logic [7:0] in_byte;
        logic       msg_start;
    } t_in_item;

    // one result
    typedef struct packed {
        logic [7:0] body_byte;
        logic [1:0] status;
    } t_out_item;

    // decode stage result toward the output register
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_dec_res;

    // hex digit decode: {not_hex, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b0, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/chd_decode.sv
// ----------------------------------------------------------------------------
// chd_decode: chunked framing state machine
// Holds phase, chunk size / bytes left and digit count; turns one byte per
// enabled cycle into zero or one result.
// ----------------------------------------------------------------------------
module chd_decode #(
    parameter int SIZE_BITS = chd_pkg::SIZE_BITS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  chd_pkg::t_in_item i_item,
    output chd_pkg::t_dec_res o_res
);

    localparam int MaxDigits = SIZE_BITS / 4;
    localparam int DcntW     = $clog2(MaxDigits + 1);

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_SIZE_LF,
        PH_DATA,
        PH_DATA_CR,
        PH_DATA_LF,
        PH_LAST_CR,
        PH_LAST_LF,
        PH_DONE
    } t_phase;

    t_phase               r_phase, n_phase;
    logic [SIZE_BITS-1:0] r_remaining, n_remaining;
    logic [DcntW-1:0]     r_digits, n_digits;

    t_phase               cur_phase;
    logic [SIZE_BITS-1:0] cur_remaining;
    logic [DcntW-1:0]     cur_digits;
    logic [4:0]           hex;
    logic [SIZE_BITS-1:0] dec_remaining;
    logic [7:0]           c;

    // restart at a size line when msg_start is set
    assign cur_phase     = i_item.msg_start ? PH_SIZE : r_phase;
    assign cur_remaining = i_item.msg_start ? '0 : r_remaining;
    assign cur_digits    = i_item.msg_start ? '0 : r_digits;
    assign c             = i_item.in_byte;
    assign hex           = chd_pkg::hex_value(c);
    assign dec_remaining = cur_remaining - 1'b1;

    // next state and result
    always_comb begin
        n_phase                 = cur_phase;
        n_remaining             = cur_remaining;
        n_digits                = cur_digits;
        o_res.valid             = 1'b0;
        o_res.item.body_byte    = 8'h00;
        o_res.item.status       = chd_pkg::ST_BODY;
        case (cur_phase)
            PH_SIZE: begin
                if (c == chd_pkg::CH_CR) begin
                    n_phase = PH_SIZE_LF;
                end else if (hex[4] || cur_digits >= DcntW'(MaxDigits)) begin
                    n_phase           = PH_DONE;
                    o_res.valid       = 1'b1;
                    o_res.item.status = chd_pkg::ST_MALFORMED;
                end else begin
                    n_remaining = {cur_remaining[SIZE_BITS-5:0], hex[3:0]};
                    n_digits    = cur_digits + 1'b1;
                end
            end
            PH_SIZE_LF: begin
                if (c != chd_pkg::CH_LF) begin
                    n_phase           = PH_DONE;
                    o_res.valid       = 1'b1;
                    o_res.item.status = chd_pkg::ST_MALFORMED;
                end else if (cur_digits == '0) begin
                    n_phase           = PH_DONE;
                    o_res.valid       = 1'b1;
                    o_res.item.status = chd_pkg::ST_COMPLETE;
                end else begin
                    n_phase = (cur_remaining == '0) ? PH_LAST_CR : PH_DATA;
                end
            end
            PH_DATA: begin
                o_res.valid          = 1'b1;
                o_res.item.body_byte = c;
                n_remaining          = dec_remaining;
                if (dec_remaining == '0) begin
                    n_phase = PH_DATA_CR;
                end
            end
            PH_DATA_CR, PH_LAST_CR: begin
                if (c != chd_pkg::CH_CR) begin
                    n_phase           = PH_DONE;
                    o_res.valid       = 1'b1;
                    o_res.item.status = chd_pkg::ST_MALFORMED;
                end else begin
                    n_phase = (cur_phase == PH_DATA_CR) ? PH_DATA_LF : PH_LAST_LF;
                end
            end
            PH_DATA_LF: begin
                if (c != chd_pkg::CH_LF) begin
                    n_phase           = PH_DONE;
                    o_res.valid       = 1'b1;
                    o_res.item.status = chd_pkg::ST_MALFORMED;
                end else begin
                    n_phase     = PH_SIZE;
                    n_remaining = '0;
                    n_digits    = '0;
                end
            end
            PH_LAST_LF: begin
                n_phase     = PH_DONE;
                o_res.valid = 1'b1;
                if (c != chd_pkg::CH_LF) begin
                    o_res.item.status = chd_pkg::ST_MALFORMED;
                end else begin
                    o_res.item.status = chd_pkg::ST_COMPLETE;
                end
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SIZE;
            r_remaining <= '0;
            r_digits    <= '0;
        end else if (i_en) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_digits    <= n_digits;
        end
    end

endmodule

FILE: rtl/core/http_chunked_body_decoder_core.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core: HTTP chunked transfer body decoder
// Strips chunk framing from a body byte stream and reports message end.
// ----------------------------------------------------------------------------
// Takes one byte per clock (sustained one request per cycle) while the result
// side does not stall, and gives at most one result per byte: the byte sits
// in an input register, the framing state machine decodes it combinationally
// and the result lands in an output register. A stall on the result side
// holds the input register, and the input side takes no new byte while that
// register is full. Status 0 carries a data byte, 1 marks a complete message,
// 2 a malformed framing line; after either end, bytes give no result until a
// request with msg_start set. Chunk sizes are limited to SIZE_BITS/4 hex
// digits; extensions and trailers are rejected as malformed.
module http_chunked_body_decoder_core #(
    parameter int SIZE_BITS = chd_pkg::SIZE_BITS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  chd_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output chd_pkg::t_out_item o_out_data
);

    logic               r_in_valid;
    chd_pkg::t_in_item  r_in_item;
    logic               r_out_valid;
    chd_pkg::t_out_item r_out_item;
    logic               out_free;
    logic               advance;
    chd_pkg::t_dec_res  dec_res;

    // the decode step runs whenever the output slot can take its result
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_data;
        end
    end

    // framing state machine
    chd_decode #(
        .SIZE_BITS(SIZE_BITS)
    ) u_decode (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (advance),
        .i_item (r_in_item),
        .o_res  (dec_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && dec_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && dec_res.valid) begin
            r_out_item <= dec_res.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for http_chunked_body_decoder_core
// Drives chunked body bytes through the request channel with random bursts
// and gaps while the result side stalls on its own pattern. A behavioral
// decoder predicts each result, and every accepted result is compared with
// the oldest prediction. Directed framing cases come first, then a long
// output hold-off, then randomized messages with corruption and restarts.
// ----------------------------------------------------------------------------
module tb;

    localparam int SIZE_BITS    = chd_pkg::SIZE_BITS_DEFAULT;
    localparam int MAX_DIGITS   = SIZE_BITS / 4;
    localparam int LIVE_TARGET  = 740;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;

    // decoder framing phases
    typedef enum logic [2:0] {
        P_SIZE, P_SIZE_LF, P_DATA, P_DATA_CR, P_DATA_LF, P_LAST_CR, P_LAST_LF, P_ENDED
    } t_dec_phase;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    chd_pkg::t_in_item  i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    chd_pkg::t_out_item o_out_data;

    // predicted decoder state
    t_dec_phase             dec_phase;
    logic [SIZE_BITS-1:0]   dec_left;
    int                     dec_digits;

    chd_pkg::t_out_item expected_results[$];
    logic [7:0]         frame_bytes[$];
    int                 mismatch_count;
    int                 live_items;
    int                 burst_left;
    int                 rx_hold_left;

    http_chunked_body_decoder_core #(
        .SIZE_BITS (SIZE_BITS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #1600000;
        $display("tb: failure");
        $finish;
    end

    // hex digit value, bit 4 set for a non-hex byte
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] low;
        low = c | 8'h20;
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b0, c[3:0]};
        end else if (low >= 8'h61 && low <= 8'h66) begin
            return {1'b0, 4'(c[3:0] + 4'd9)};
        end
        return 5'h10;
    endfunction

    // one byte through the framing decoder, returns 1 when a result comes out
    function automatic logic decode_chunk_byte(input chd_pkg::t_in_item req,
                                               output chd_pkg::t_out_item res);
        logic [4:0] nib;
        logic       ending;
        logic       hit;
        logic [1:0] end_code;
        res      = '0;
        ending   = 1'b0;
        hit      = 1'b0;
        end_code = chd_pkg::ST_MALFORMED;
        if (req.msg_start) begin
            dec_phase  = P_SIZE;
            dec_left   = '0;
            dec_digits = 0;
        end
        nib = hex_nibble(req.in_byte);
        case (dec_phase)
            P_SIZE: begin
                if (req.in_byte == chd_pkg::CH_CR) begin
                    dec_phase = P_SIZE_LF;
                end else if (nib[4] || dec_digits >= MAX_DIGITS) begin
                    ending = 1'b1;
                end else begin
                    dec_left   = (dec_left << 4) | SIZE_BITS'(nib[3:0]);
                    dec_digits = dec_digits + 1;
                end
            end
            P_SIZE_LF: begin
                if (req.in_byte != chd_pkg::CH_LF) begin
                    ending = 1'b1;
                end else if (dec_digits == 0) begin
                    ending   = 1'b1;
                    end_code = chd_pkg::ST_COMPLETE;
                end else begin
                    dec_phase = (dec_left == '0) ? P_LAST_CR : P_DATA;
                end
            end
            P_DATA: begin
                hit           = 1'b1;
                res.body_byte = req.in_byte;
                res.status    = chd_pkg::ST_BODY;
                dec_left      = dec_left - 1'b1;
                if (dec_left == '0) dec_phase = P_DATA_CR;
            end
            P_DATA_CR: begin
                if (req.in_byte != chd_pkg::CH_CR) ending = 1'b1;
                else dec_phase = P_DATA_LF;
            end
            P_DATA_LF: begin
                if (req.in_byte != chd_pkg::CH_LF) begin
                    ending = 1'b1;
                end else begin
                    dec_phase  = P_SIZE;
                    dec_left   = '0;
                    dec_digits = 0;
                end
            end
            P_LAST_CR: begin
                if (req.in_byte != chd_pkg::CH_CR) ending = 1'b1;
                else dec_phase = P_LAST_LF;
            end
            P_LAST_LF: begin
                ending = 1'b1;
                if (req.in_byte == chd_pkg::CH_LF) end_code = chd_pkg::ST_COMPLETE;
            end
            default: ;
        endcase
        if (ending) begin
            hit        = 1'b1;
            res        = '0;
            res.status = end_code;
            dec_phase  = P_ENDED;
        end
        return hit;
    endfunction

    // send one request, predict at the accepting edge, then maybe idle
    task automatic send_byte(input logic [7:0] b, input logic start);
        chd_pkg::t_in_item  req;
        chd_pkg::t_out_item res;
        int                 gap;
        req.in_byte   = b;
        req.msg_start = start;
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        if (dec_phase != P_ENDED || start) live_items++;
        if (decode_chunk_byte(req, res)) expected_results.push_back(res);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_text(input string s, input logic start);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], start && i == 0);
        end
    endtask

    // hex digit character in random case
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + nib;
        return (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + nib - 8'd10;
    endfunction

    // size line digits with leading zeros, no CR LF
    task automatic push_size_line(input int value, input int pad);
        int n;
        n = 1;
        while (n < 8 && (value >> (4 * n)) != 0) n++;
        repeat (pad) frame_bytes.push_back(8'h30);
        for (int i = n - 1; i >= 0; i--) begin
            frame_bytes.push_back(hex_char(4'((value >> (4 * i)) & 15)));
        end
    endtask

    // data bytes at both byte extremes, then zero chunk and end
    task automatic test_basic_chunks();
        send_text("2\015\012", 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("\015\012", 1'b0);
        send_text("0\015\012\015\012", 1'b0);
    endtask

    // an empty size line ends the message
    task automatic test_empty_size_line();
        send_text("\015\012", 1'b1);
    endtask

    // non-hex byte on a size line, then a byte that must be ignored
    task automatic test_bad_digit();
        send_text("G7", 1'b1);
    endtask

    // one digit more than the size register holds, leading zeros included
    task automatic test_digit_overflow();
        send_text("000000000", 1'b1);
    endtask

    // long receiver hold-off while a long chunk keeps coming
    task automatic test_output_backpressure();
        rx_hold_left = HOLD_CYCLES;
        send_text("40\015\012", 1'b1);
        repeat (64) send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_text("\015\012", 1'b0);
        send_text("0\015\012\015\012", 1'b0);
    endtask

    // random messages: mostly well formed, some corrupted, wide or noise
    task automatic test_random_traffic();
        int kind;
        int n_chunks;
        int len;
        int pos;
        while (live_items < LIVE_TARGET) begin
            frame_bytes.delete();
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                n_chunks = $urandom_range(0, 3);
                for (int c = 0; c < n_chunks; c++) begin
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                      : $urandom_range(1, 8);
                    push_size_line(len, ($urandom_range(0, 9) == 0) ?
                                   $urandom_range(0, 9) : $urandom_range(0, 2));
                    frame_bytes.push_back(chd_pkg::CH_CR);
                    frame_bytes.push_back(chd_pkg::CH_LF);
                    repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
                    frame_bytes.push_back(chd_pkg::CH_CR);
                    frame_bytes.push_back(chd_pkg::CH_LF);
                end
                if ($urandom_range(0, 5) != 0) begin
                    push_size_line(0, $urandom_range(0, 3));
                    frame_bytes.push_back(chd_pkg::CH_CR);
                    frame_bytes.push_back(chd_pkg::CH_LF);
                end
                frame_bytes.push_back(chd_pkg::CH_CR);
                frame_bytes.push_back(chd_pkg::CH_LF);
                // damage one byte now and then
                if ($urandom_range(0, 3) == 0) begin
                    pos = $urandom_range(0, frame_bytes.size() - 1);
                    case ($urandom_range(0, 3))
                        0:       frame_bytes[pos] = 8'($urandom_range(0, 255));
                        1:       frame_bytes[pos] = chd_pkg::CH_CR;
                        2:       frame_bytes[pos] = chd_pkg::CH_LF;
                        default: frame_bytes[pos] = 8'h30;
                    endcase
                end
            end else if (kind == 7) begin
                // full-width or too-wide size line, then a few data bytes
                len = ($urandom_range(0, 1) != 0) ? MAX_DIGITS : $urandom_range(9, 11);
                repeat (len) frame_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
                frame_bytes.push_back(chd_pkg::CH_CR);
                frame_bytes.push_back(chd_pkg::CH_LF);
                repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 10)) frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
            // trailing bytes after the end are ignored by the block
            if ($urandom_range(0, 4) == 0) frame_bytes.push_back(8'($urandom_range(0, 255)));
            for (int k = 0; k < frame_bytes.size(); k++) begin
                send_byte(frame_bytes[k], k == 0 || $urandom_range(0, 149) == 0);
            end
        end
    endtask

    // result side stall pattern, with an optional long hold-off
    initial begin : result_stall
        int   rx_tick;
        int   rx_mode;
        logic rdy;
        rx_tick     = 0;
        rx_mode     = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_tick % 50 == 0) rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0:       rdy = 1'b1;
                1:       rdy = 1'($urandom_range(0, 1));
                2:       rdy = (rx_tick % 4 == 0);
                default: rdy = ($urandom_range(0, 7) != 0);
            endcase
            if (rx_hold_left > 0) begin
                rdy          = 1'b0;
                rx_hold_left = rx_hold_left - 1;
            end
            i_out_ready <= rdy;
            rx_tick++;
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        chd_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: body_byte %h status %0d",
                       o_out_data.body_byte, o_out_data.status);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d actual %0d", want.status, o_out_data.status);
                    mismatch_count++;
                end
                if (o_out_data.body_byte !== want.body_byte) begin
                    $error("body_byte: expected %h actual %h",
                           want.body_byte, o_out_data.body_byte);
                    mismatch_count++;
                end
            end
        end
    end

    // main sequence
    initial begin
        mismatch_count = 0;
        live_items     = 0;
        burst_left     = 0;
        rx_hold_left   = 0;
        dec_phase      = P_SIZE;
        dec_left       = '0;
        dec_digits     = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_chunks();
        test_empty_size_line();
        test_bad_digit();
        test_digit_overflow();
        test_output_backpressure();
        test_random_traffic();

        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: http_chunked_body_decoder_core.f
rtl/core/chd_pkg.sv
rtl/core/chd_decode.sv
rtl/core/http_chunked_body_decoder_core.sv
dv/tb.sv
